// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL files.
// Depends on nothing; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, gated off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/pwlti_pkg.sv =====
// Constants, breakpoint tables and helpers for the piecewise-linear lookup.
// Depends on nothing; used by piecewise_linear_table_interp.
`default_nettype none

package pwlti_pkg;

  // Table select codes
  localparam logic [1:0] MODE_FINE = 2'd0;
  localparam logic [1:0] MODE_C1   = 2'd1;
  localparam logic [1:0] MODE_C2   = 2'd2;
  localparam logic [1:0] MODE_OFF  = 2'd3;

  localparam int DIST_FRAC_BITS_DEF = 8;

  localparam int DIST_W = 16;
  localparam int PROB_W = 17;
  localparam int MM_W   = 7;   // whole millimetres, all breakpoints below 128
  localparam int SPAN_W = 4;   // spacing in mm fits 4 bits (2 or 10)
  localparam int Q_W    = 6;   // coarse step count, offset / 2 mm

  // Breakpoint positions in whole mm
  localparam logic [MM_W-1:0] FINE_LO_MM   = 7'd10;
  localparam logic [MM_W-1:0] FINE_HI_MM   = 7'd50;
  localparam logic [MM_W-1:0] COARSE_LO_MM = 7'd5;
  localparam logic [MM_W-1:0] C1_HI_MM     = 7'd85;
  localparam logic [MM_W-1:0] C2_HI_MM     = 7'd95;

  localparam logic [SPAN_W-1:0] SPAN2_MM  = 4'd2;
  localparam logic [SPAN_W-1:0] SPAN10_MM = 4'd10;

  // Last fine segment is the wide one from 40 to 50 mm
  localparam logic [3:0] FINE_LAST_SEG = 4'd15;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  // ceil(2^22 / 5): exact divide by 5 for values below 2^22
  localparam int               RECIP5_W     = 20;
  localparam int               RECIP5_SHIFT = 22;
  localparam logic [RECIP5_W-1:0] RECIP5    = 20'd838861;

  localparam logic [PROB_W-1:0] FINE_TAB [17] = '{
    17'd65536, 17'd52429, 17'd47514, 17'd40960, 17'd36045, 17'd29491,
    17'd24576, 17'd19661, 17'd16384, 17'd10486, 17'd8192,  17'd5243,
    17'd4588,  17'd2621,  17'd1638,  17'd1311,  17'd0
  };

  localparam logic [PROB_W-1:0] C1_TAB [9] = '{
    17'd49448, 17'd47719, 17'd43404, 17'd34869, 17'd23542, 17'd14099,
    17'd8362,  17'd5339,  17'd4672
  };

  localparam logic [PROB_W-1:0] C2_TAB [10] = '{
    17'd57153, 17'd56884, 17'd54023, 17'd49712, 17'd42111, 17'd30313,
    17'd18263, 17'd9510,  17'd4910,  17'd3040
  };

  // Divide a small step count by 5: (q * 13) >> 6, exact for q < 64
  function automatic logic [3:0] div5_small(input logic [Q_W-1:0] q);
    logic [9:0] acc;
    acc = 10'({q, 3'b000}) + 10'({q, 2'b00}) + 10'(q);
    return acc[9:6];
  endfunction

  // Table entry for a mode and point index; out-of-range reads give zero
  function automatic logic [PROB_W-1:0] tab_val(input logic [1:0] mode,
                                                input logic [4:0] idx);
    logic [PROB_W-1:0] v;
    v = '0;
    case (mode)
      MODE_FINE: v = (idx <= 5'd16) ? FINE_TAB[idx] : '0;
      MODE_C1:   v = (idx <= 5'd8)  ? C1_TAB[idx[3:0]] : '0;
      MODE_C2:   v = (idx <= 5'd9)  ? C2_TAB[idx[3:0]] : '0;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/piecewise_linear_table_interp.sv =====
// Piecewise-linear probability lookup: distance in, Q1.16 probability out.
// Depends on pwlti_pkg and assert_macros.svh.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -----------------------
//  input     start, busy, in_distance                start & !busy
//  result    out_valid, out_probability              strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_table_mode    cfg_valid & cfg_ready
//
// One request per cycle.
// Pipeline: input reg, segment select reg, product reg (two 17xN multiplies),
// result reg (rounding, divide by spacing with a reciprocal multiply).
// busy and cfg_ready are always low / high: no stalls on either side.
// rst_n is synchronous; it clears the valid pipeline and sets table_mode to 0.
`default_nettype none

module piecewise_linear_table_interp
  import pwlti_pkg::*;
#(
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DIST_W-1:0] in_distance,
  // result channel
  output logic                   out_valid,
  output logic [PROB_W-1:0]      out_probability,
  // configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_table_mode
);

`include "assert_macros.svh"

  localparam int FB  = DIST_FRAC_BITS;
  localparam int BW  = MM_W + FB;                  // raw breakpoint width
  localparam int CW  = (BW > DIST_W) ? BW : DIST_W; // compare width
  localparam int RW  = SPAN_W + FB;                // offset within segment
  localparam int PW  = PROB_W + RW;                // one product
  localparam int NW  = PW + 1;                     // rounded sum
  localparam int QW  = NW - (FB + 1);              // sum scaled by 2^-(FB+1)
  localparam int MW  = QW + RECIP5_W;              // reciprocal product

  localparam logic [RW-1:0] SPAN2_RAW  = RW'(SPAN2_MM) << FB;
  localparam logic [RW-1:0] SPAN10_RAW = RW'(SPAN10_MM) << FB;

  // Configuration register
  logic [1:0] table_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_mode_r <= MODE_FINE;
    end else if (cfg_valid && cfg_ready) begin
      table_mode_r <= cfg_table_mode;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Input register
  logic              v0_r;
  logic [DIST_W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      d_r <= in_distance;
    end
  end

  // Stage 1: range check, segment select, offset and table reads
  logic              v1_r;
  logic [PROB_W-1:0] s1_y0_r, s1_y0_nxt;
  logic [PROB_W-1:0] s1_y1_r, s1_y1_nxt;
  logic [RW-1:0]     s1_r_r, s1_r_nxt;
  logic              s1_is10_r, s1_is10_nxt;
  logic              s1_sp_r, s1_sp_nxt;
  logic [PROB_W-1:0] s1_spv_r, s1_spv_nxt;

  logic [CW-1:0]   d_ext;
  logic [MM_W-1:0] lo_mm, hi_mm, bp_mm;
  logic [CW-1:0]   off, rr;
  logic [Q_W-1:0]  q;
  logic [3:0]      seg;
  logic [4:0]      seg_x;
  logic            fine;

  always_comb begin
    d_ext = CW'(d_r);
    fine  = (table_mode_r == MODE_FINE);
    lo_mm = fine ? FINE_LO_MM : COARSE_LO_MM;
    case (table_mode_r)
      MODE_FINE: hi_mm = FINE_HI_MM;
      MODE_C1:   hi_mm = C1_HI_MM;
      default:   hi_mm = C2_HI_MM;
    endcase
    // step count in 2 mm units; valid whenever distance is in range
    off = d_ext - (CW'(lo_mm) << FB);
    q   = off[FB+Q_W:FB+1];
    if (fine) begin
      seg = (q > Q_W'(FINE_LAST_SEG)) ? FINE_LAST_SEG : q[3:0];
    end else begin
      seg = div5_small(q);
    end
    seg_x = {1'b0, seg};
    // segment start in mm
    if (fine) begin
      bp_mm = FINE_LO_MM + MM_W'({seg, 1'b0});
    end else begin
      bp_mm = COARSE_LO_MM + MM_W'({seg, 3'b000}) + MM_W'({seg, 1'b0});
    end
    rr = d_ext - (CW'(bp_mm) << FB);

    s1_y0_nxt   = tab_val(table_mode_r, seg_x);
    s1_y1_nxt   = tab_val(table_mode_r, seg_x + 5'd1);
    s1_r_nxt    = rr[RW-1:0];
    s1_is10_nxt = !fine || (seg == FINE_LAST_SEG);

    // constant results: mode off, below first and past last breakpoint
    s1_sp_nxt  = 1'b1;
    s1_spv_nxt = '0;
    if (table_mode_r == MODE_OFF) begin
      s1_spv_nxt = '0;
    end else if (d_ext < (CW'(lo_mm) << FB)) begin
      s1_spv_nxt = fine ? PROB_ONE : tab_val(table_mode_r, 5'd0);
    end else if (d_ext >= (CW'(hi_mm) << FB)) begin
      s1_spv_nxt = '0;
    end else begin
      s1_sp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_y0_r   <= s1_y0_nxt;
    s1_y1_r   <= s1_y1_nxt;
    s1_r_r    <= s1_r_nxt;
    s1_is10_r <= s1_is10_nxt;
    s1_sp_r   <= s1_sp_nxt;
    s1_spv_r  <= s1_spv_nxt;
  end

  // Stage 2: weighted end values
  logic              v2_r;
  logic [PW-1:0]     s2_p0_r, s2_p0_nxt;
  logic [PW-1:0]     s2_p1_r, s2_p1_nxt;
  logic              s2_is10_r;
  logic              s2_sp_r;
  logic [PROB_W-1:0] s2_spv_r;
  logic [RW-1:0]     span, span_m_r;

  always_comb begin
    span      = s1_is10_r ? SPAN10_RAW : SPAN2_RAW;
    span_m_r  = span - s1_r_r;
    s2_p0_nxt = PW'(s1_y0_r) * PW'(span_m_r);
    s2_p1_nxt = PW'(s1_y1_r) * PW'(s1_r_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_p0_r   <= s2_p0_nxt;
    s2_p1_r   <= s2_p1_nxt;
    s2_is10_r <= s1_is10_r;
    s2_sp_r   <= s1_sp_r;
    s2_spv_r  <= s1_spv_r;
  end

  // Stage 3: round, divide by spacing (2^(FB+1), times 5 for 10 mm)
  logic              out_valid_r;
  logic [PROB_W-1:0] out_probability_r, out_probability_nxt;
  logic [NW-1:0]     num;
  logic [QW-1:0]     qt;
  logic [MW-1:0]     q5;
  logic [RW-1:0]     half;

  always_comb begin
    half = s2_is10_r ? (SPAN10_RAW >> 1) : (SPAN2_RAW >> 1);
    num  = NW'(s2_p0_r) + NW'(s2_p1_r) + NW'(half);
    qt   = QW'(num >> (FB + 1));
    q5   = MW'(qt) * MW'(RECIP5);
    if (s2_sp_r) begin
      out_probability_nxt = s2_spv_r;
    end else if (s2_is10_r) begin
      out_probability_nxt = q5[RECIP5_SHIFT +: PROB_W];
    end else begin
      out_probability_nxt = qt[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_probability_r <= out_probability_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_probability_r;

  // Checks
  `ASSERT_IMPLY(a_strobe_from_pipe, clk, rst_n, out_valid_r, $past(v2_r))
  `ASSERT_IMPLY(a_prob_in_range, clk, rst_n, out_valid_r, out_probability_r <= PROB_ONE)
  `ASSERT_NEXT(a_mode_off_zero, clk, rst_n, v0_r && (table_mode_r == MODE_OFF), s1_sp_r && (s1_spv_r == '0))
  `ASSERT_IMPLY(a_offset_in_seg, clk, rst_n, v1_r && !s1_sp_r, s1_r_r < (s1_is10_r ? SPAN10_RAW : SPAN2_RAW))

endmodule

`default_nettype wire

// ===== test/tb_piecewise_linear_table_interp.sv =====
// Self-checking bench for piecewise_linear_table_interp: distances in, Q1.16 probabilities out.
// Depends on pwlti_pkg for the mode codes. A local model of the breakpoint tables predicts each
// result; phases cycle through every table mode.
`default_nettype none

module tb_piecewise_linear_table_interp
  import pwlti_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC      = 8;
  localparam int          LIMIT     = 200_000;
  localparam int unsigned ONE_Q16   = 65536;
  localparam int          MAX_PRINT = 30;

  // Breakpoint values, Q1.16
  localparam int unsigned FINE_PTS [17] = '{
    65536, 52429, 47514, 40960, 36045, 29491, 24576, 19661, 16384,
    10486, 8192, 5243, 4588, 2621, 1638, 1311, 0
  };
  localparam int unsigned COARSE_A_PTS [9] = '{
    49448, 47719, 43404, 34869, 23542, 14099, 8362, 5339, 4672
  };
  localparam int unsigned COARSE_B_PTS [10] = '{
    57153, 56884, 54023, 49712, 42111, 30313, 18263, 9510, 4910, 3040
  };

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [15:0] in_distance    = '0;
  logic        cfg_valid      = 1'b0;
  logic [1:0]  cfg_table_mode = '0;
  logic        busy;
  logic        out_valid;
  logic [16:0] out_probability;
  logic        cfg_ready;

  // Request bookkeeping
  logic [15:0] distance_q [$];
  logic [16:0] prob_expect_q [$];
  int          issued_cnt    = 0;
  int          accepted_cnt  = 0;
  int          mismatch_cnt  = 0;
  int          cycle_cnt     = 0;
  int          zero_cnt      = 0;
  int          full_cnt      = 0;
  int          mode_hits [4] = '{0, 0, 0, 0};
  logic        req_taken     = 1'b0;
  logic [1:0]  cur_mode      = MODE_FINE;
  int          burst_left    = 1;
  int          gap_left      = 0;

  piecewise_linear_table_interp i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_distance    (in_distance),
    .out_valid      (out_valid),
    .out_probability(out_probability),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_table_mode (cfg_table_mode)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned seg_blend(input int unsigned y0, input int unsigned y1,
                                            input int unsigned r, input int unsigned span);
    longint unsigned acc;
    acc = 64'(y0) * 64'(span - r) + 64'(y1) * 64'(r);
    return int'((acc + 64'(span / 2)) / 64'(span));
  endfunction

  function automatic int unsigned table_point(input logic [1:0] sel, input int unsigned idx);
    case (sel)
      MODE_FINE: return FINE_PTS[idx];
      MODE_C1:   return COARSE_A_PTS[idx];
      MODE_C2:   return COARSE_B_PTS[idx];
      default:   return 0;
    endcase
  endfunction

  // Evenly spaced table: n points starting at base_mm, step_mm apart
  function automatic int unsigned uniform_segment(input logic [1:0] sel, input int unsigned n,
                                                  input int unsigned base_mm,
                                                  input int unsigned step_mm,
                                                  input int unsigned d);
    int unsigned span, lo, hi, off, idx;
    span = step_mm << FRAC;
    lo   = base_mm << FRAC;
    hi   = (base_mm + step_mm * (n - 1)) << FRAC;
    if (d < lo) return table_point(sel, 0);
    if (d >= hi) return 0;
    off = d - lo;
    idx = off / span;
    if (idx > n - 2) idx = n - 2;
    return seg_blend(table_point(sel, idx), table_point(sel, idx + 1), off - idx * span, span);
  endfunction

  function automatic logic [16:0] predict_probability(input logic [1:0] mode,
                                                      input logic [15:0] dist_raw);
    int unsigned d, p;
    d = dist_raw;
    case (mode)
      MODE_FINE: begin
        // flat 1.0 below 10 mm; 2 mm steps to 40 mm; one wide segment to 50 mm
        if (d < (10 << FRAC)) p = ONE_Q16;
        else if (d < (40 << FRAC)) p = uniform_segment(MODE_FINE, 16, 10, 2, d);
        else if (d < (50 << FRAC))
          p = seg_blend(FINE_PTS[15], FINE_PTS[16], d - (40 << FRAC), 10 << FRAC);
        else p = 0;
      end
      MODE_C1: p = uniform_segment(MODE_C1, 9, 5, 10, d);
      MODE_C2: p = uniform_segment(MODE_C2, 10, 5, 10, d);
      default: p = 0;
    endcase
    return p[16:0];
  endfunction

  // ---------------------------------------------------------------- driver

  // New request or idle at the falling edge once the current one has gone in
  always @(negedge clk) begin
    if (!start || req_taken) begin
      if (gap_left != 0) begin
        start       <= 1'b0;
        in_distance <= 16'($urandom);
        gap_left    <= gap_left - 1;
      end else if (distance_q.size() != 0) begin
        start       <= 1'b1;
        in_distance <= distance_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start       <= 1'b0;
        in_distance <= 16'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINT) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
      cur_mode  <= MODE_FINE;
    end else begin
      req_taken <= start && !busy;
      // result check against the oldest pending prediction
      if (out_valid) begin
        if (prob_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", out_probability));
        end else begin
          if (out_probability !== prob_expect_q[0])
            report_mismatch($sformatf("probability got %0d want %0d",
                                      out_probability, prob_expect_q[0]));
          if (prob_expect_q[0] == 0) zero_cnt++;
          if (prob_expect_q[0] == ONE_Q16) full_cnt++;
          void'(prob_expect_q.pop_front());
        end
      end
      // accepted request: predict with the mode in force before this edge
      if (start && !busy) begin
        prob_expect_q.push_back(predict_probability(cur_mode, in_distance));
        mode_hits[cur_mode]++;
        accepted_cnt <= accepted_cnt + 1;
      end
      if (cfg_valid && cfg_ready) cur_mode <= cfg_table_mode;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("piecewise_linear_table_interp regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_request(input int unsigned d);
    distance_q.push_back(d[15:0]);
    issued_cnt++;
  endtask

  // Hold off until every request is in and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (distance_q.size() != 0 || accepted_cnt != issued_cnt || prob_expect_q.size() != 0);
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_table_mode <= m;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly the interesting 0..100 mm span, some around breakpoints, some anywhere
  function automatic int unsigned rand_distance();
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom_range(0, 65535);
      2, 3: begin
        v = $urandom_range(0, 96) * 256 + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
      end
      default: v = $urandom_range(0, 100 * 256);
    endcase
    return v;
  endfunction

  initial begin
    logic [1:0] mode;
    int         n_items;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fine table straight out of reset, edges and segment transitions
    push_request(0);
    push_request(10 * 256 - 1);
    push_request(10 * 256);
    push_request(11 * 256);
    push_request(40 * 256 - 1);
    push_request(40 * 256);
    push_request(45 * 256);
    push_request(50 * 256 - 1);
    push_request(50 * 256);
    push_request(16'hFFFF);
    wait_idle();

    // First coarse table: clamp below 5 mm, zero from 85 mm
    write_mode(MODE_C1);
    push_request(0);
    push_request(5 * 256 - 1);
    push_request(5 * 256);
    push_request(10 * 256);
    push_request(85 * 256 - 1);
    push_request(85 * 256);
    push_request(16'hFFFF);
    wait_idle();

    // Second coarse table
    write_mode(MODE_C2);
    push_request(0);
    push_request(50 * 256 + 128);
    push_request(95 * 256 - 1);
    push_request(95 * 256);
    wait_idle();

    // Zero mode
    write_mode(MODE_OFF);
    push_request(0);
    push_request(30 * 256);
    push_request(16'hFFFF);
    wait_idle();

    // Random phases, each drained before the next mode write
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       mode = MODE_FINE;
        1:       mode = MODE_OFF;
        2:       mode = MODE_C1;
        3:       mode = MODE_C2;
        default: mode = 2'($urandom_range(0, 3));
      endcase
      write_mode(mode);
      n_items = $urandom_range(140, 185);
      for (int i = 0; i < n_items; i++) push_request(rand_distance());
      wait_idle();
    end

    repeat (12) @(negedge clk);
    $display("%0d requests checked: fine %0d, coarse-1 %0d, coarse-2 %0d, zero mode %0d",
             accepted_cnt, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("%0d results at zero, %0d at full scale, %0d mismatches",
             zero_cnt, full_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("piecewise_linear_table_interp regression: pass");
    end else begin
      $display("piecewise_linear_table_interp regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pwlti_pkg.sv
hw/rtl/piecewise_linear_table_interp.sv
test/tb_piecewise_linear_table_interp.sv
